// ----- rtl/core/chacha_pkg.sv -----
// Shared types, constants and round function of the ChaCha20 stream cipher unit.
package chacha_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_KEY0    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY1    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEY2    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_KEY3    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_KEY_256 = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_NONCE   = 3'd5;

  // "expand 32-byte k" and "expand 16-byte k"
  localparam logic [3:0][31:0] SIGMA = {32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865};
  localparam logic [3:0][31:0] TAU   = {32'h6b206574, 32'h79622d36, 32'h3120646e, 32'h61707865};

  typedef struct packed {
    logic [63:0] msg;
    logic [3:0]  cnt;
    logic        endf;
  } item_t;

  typedef struct packed {
    logic [3:0][63:0] key;
    logic             key_256;
    logic [63:0]      nonce;
    logic             nonce_wr;
  } cfg_t;

  typedef struct packed {
    logic gen_busy;
    logic step;
  } back_status_t;

  typedef enum logic {
    BK_RUN,
    BK_GEN
  } back_state_e;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  // Quarter round; result packed as {a, b, c, d}.
  function automatic logic [127:0] quarter(input logic [31:0] a_in, input logic [31:0] b_in,
                                           input logic [31:0] c_in, input logic [31:0] d_in);
    logic [31:0] a, b, c, d;
    a = a_in; b = b_in; c = c_in; d = d_in;
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
    quarter = {a, b, c, d};
  endfunction

endpackage

// ----- rtl/core/chacha_front.sv -----
// Front end: input acceptance, byte count saturation and a two-entry item queue.
module chacha_front #(
  parameter int unsigned Limit = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [63:0]         message_bytes_i,
  input  logic [3:0]          byte_count_i,
  input  logic                message_end_i,
  output logic                head_valid_o,
  output chacha_pkg::item_t   head_o,
  input  logic                pop_i
);
  import chacha_pkg::*;

  item_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] fill_q;
  logic       push;
  item_t      wr_item;

  assign in_ready_o   = (fill_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign head_valid_o = (fill_q != 2'd0);
  assign head_o       = mem_q[rptr_q];

  always_comb begin
    wr_item.msg  = message_bytes_i;
    wr_item.cnt  = (byte_count_i > 4'(Limit)) ? 4'(Limit) : byte_count_i;
    wr_item.endf = message_end_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      fill_q <= fill_q + 2'(push) - 2'(pop_i);
    end
  end

endmodule

// ----- rtl/core/chacha_core.sv -----
// Block function: one column or diagonal round per cycle, then feed-forward add.
module chacha_core #(
  parameter int unsigned NumRounds = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [15:0][31:0] init_i,
  output logic              done_o,
  output logic [15:0][31:0] block_o
);
  import chacha_pkg::*;

  localparam int unsigned RndW = $clog2(NumRounds);

  logic [15:0][31:0] w_q, w_d, init_q;
  logic [RndW-1:0]   rnd_q;
  logic              busy_q, done_q;
  logic [127:0]      q0, q1, q2, q3;

  always_comb begin
    w_d = w_q;
    if (!rnd_q[0]) begin
      q0 = quarter(w_q[0], w_q[4], w_q[8],  w_q[12]);
      q1 = quarter(w_q[1], w_q[5], w_q[9],  w_q[13]);
      q2 = quarter(w_q[2], w_q[6], w_q[10], w_q[14]);
      q3 = quarter(w_q[3], w_q[7], w_q[11], w_q[15]);
      {w_d[0], w_d[4], w_d[8],  w_d[12]} = q0;
      {w_d[1], w_d[5], w_d[9],  w_d[13]} = q1;
      {w_d[2], w_d[6], w_d[10], w_d[14]} = q2;
      {w_d[3], w_d[7], w_d[11], w_d[15]} = q3;
    end else begin
      q0 = quarter(w_q[0], w_q[5], w_q[10], w_q[15]);
      q1 = quarter(w_q[1], w_q[6], w_q[11], w_q[12]);
      q2 = quarter(w_q[2], w_q[7], w_q[8],  w_q[13]);
      q3 = quarter(w_q[3], w_q[4], w_q[9],  w_q[14]);
      {w_d[0], w_d[5], w_d[10], w_d[15]} = q0;
      {w_d[1], w_d[6], w_d[11], w_d[12]} = q1;
      {w_d[2], w_d[7], w_d[8],  w_d[13]} = q2;
      {w_d[3], w_d[4], w_d[9],  w_d[14]} = q3;
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      block_o[i] = w_q[i] + init_q[i];
    end
  end

  assign done_o = done_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      w_q    <= init_i;
      init_q <= init_i;
    end else if (busy_q) begin
      w_q <= w_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        if (rnd_q == RndW'(NumRounds - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        rnd_q <= rnd_q + RndW'(1);
      end
    end
  end

endmodule

// ----- rtl/core/chacha_back.sv -----
// Back end: keystream window, counter, XOR of queued items and output register.
module chacha_back #(
  parameter int unsigned NumRounds = 20
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  chacha_pkg::cfg_t         cfg_i,
  input  logic                     head_valid_i,
  input  chacha_pkg::item_t        head_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [63:0]              cipher_bytes_o,
  output logic [3:0]               out_byte_count_o,
  output logic                     out_message_end_o,
  output chacha_pkg::back_status_t status_o
);
  import chacha_pkg::*;

  back_state_e       state_q, state_d;
  logic [6:0]        pos_q;
  logic [3:0]        done_q;
  logic [63:0]       acc_q, acc_new;
  logic [511:0]      win_q;
  logic [63:0]       ctr_q;
  logic              out_valid_q;
  logic              out_free, run_ok, need_gen, step, finish, gen_start;
  logic [6:0]        avail;
  logic [3:0]        need, take;
  logic [15:0][31:0] init_w, block;
  logic              core_done;
  logic [3:0]        j;

  assign out_free = !out_valid_q || out_ready_i;
  assign avail    = 7'd64 - pos_q;
  assign need     = head_i.cnt - done_q;
  assign take     = (avail < 7'(need)) ? avail[3:0] : need;
  assign run_ok   = (state_q == BK_RUN) && head_valid_i && out_free;
  assign need_gen = (need != 4'd0) && (avail == 7'd0);
  assign finish   = (done_q + take == head_i.cnt);

  always_comb begin
    acc_new = acc_q;
    for (int i = 0; i < 8; i++) begin
      j = 4'(i) - done_q;
      if ((4'(i) >= done_q) && (4'(i) < done_q + take)) begin
        acc_new[i*8 +: 8] = head_i.msg[i*8 +: 8] ^ win_q[j[2:0]*8 +: 8];
      end
    end
  end

  always_comb begin
    init_w[3:0] = cfg_i.key_256 ? SIGMA : TAU;
    init_w[4]   = cfg_i.key[0][31:0];
    init_w[5]   = cfg_i.key[0][63:32];
    init_w[6]   = cfg_i.key[1][31:0];
    init_w[7]   = cfg_i.key[1][63:32];
    init_w[8]   = cfg_i.key_256 ? cfg_i.key[2][31:0]  : cfg_i.key[0][31:0];
    init_w[9]   = cfg_i.key_256 ? cfg_i.key[2][63:32] : cfg_i.key[0][63:32];
    init_w[10]  = cfg_i.key_256 ? cfg_i.key[3][31:0]  : cfg_i.key[1][31:0];
    init_w[11]  = cfg_i.key_256 ? cfg_i.key[3][63:32] : cfg_i.key[1][63:32];
    init_w[12]  = ctr_q[31:0];
    init_w[13]  = ctr_q[63:32];
    init_w[14]  = cfg_i.nonce[31:0];
    init_w[15]  = cfg_i.nonce[63:32];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_RUN:  if (run_ok && need_gen) state_d = BK_GEN;
      BK_GEN:  if (core_done) state_d = BK_RUN;
      default: state_d = BK_RUN;
    endcase
  end

  // outputs
  always_comb begin
    gen_start = 1'b0;
    step      = 1'b0;
    case (state_q)
      BK_RUN: begin
        gen_start = run_ok && need_gen;
        step      = run_ok && !need_gen;
      end
      default: ;
    endcase
  end

  assign pop_o    = step && finish;
  assign status_o = '{gen_busy: (state_q == BK_GEN), step: step};

  chacha_core #(.NumRounds(NumRounds)) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gen_start),
    .init_i  (init_w),
    .done_o  (core_done),
    .block_o (block)
  );

  always_ff @(posedge clk_i) begin
    if (core_done) begin
      win_q <= block;
    end else if (step) begin
      win_q <= win_q >> {take, 3'b000};
    end
    if (pop_o) begin
      cipher_bytes_o    <= acc_new;
      out_byte_count_o  <= head_i.cnt;
      out_message_end_o <= head_i.endf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_RUN;
      pos_q       <= 7'd64;
      done_q      <= 4'd0;
      acc_q       <= '0;
      ctr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_ready_i) out_valid_q <= 1'b0;
      if (cfg_i.nonce_wr) begin
        ctr_q <= '0;
        pos_q <= 7'd64;
      end else if (core_done) begin
        ctr_q <= ctr_q + 64'd1;
        pos_q <= 7'd0;
      end else if (step) begin
        pos_q <= (finish && head_i.endf) ? 7'd64 : pos_q + 7'(take);
      end
      if (step) begin
        if (finish) begin
          acc_q       <= '0;
          done_q      <= 4'd0;
          out_valid_q <= 1'b1;
        end else begin
          acc_q  <= acc_new;
          done_q <= done_q + take;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/core/chacha20_stream_cipher_unit.sv -----
// ChaCha20 (64-bit counter, 64-bit nonce) stream cipher unit, top level.
// An item that needs a new block waits in the queue while the block core makes it,
// one round per cycle. Throughput: one item per cycle out of a ready block while
// the output is not stalled.
// Reset: asynchronous active low; counter zero, no block held, 256-bit key mode.
module chacha20_stream_cipher_unit #(
  parameter int unsigned ROUND_COUNT    = 20,
  parameter int unsigned BYTES_PER_ITEM = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] message_bytes_i,
  input  logic [3:0]  byte_count_i,
  input  logic        message_end_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] cipher_bytes_o,
  output logic [3:0]  out_byte_count_o,
  output logic        out_message_end_o
);
  import chacha_pkg::*;

  // odd round counts finish their last double round
  localparam int unsigned NumRounds = 2 * ((ROUND_COUNT + 1) / 2);
  localparam int unsigned Limit     = (BYTES_PER_ITEM < 8) ? BYTES_PER_ITEM : 8;

  cfg_t         cfg;
  logic [3:0][63:0] key_q;
  logic         key_256_q;
  logic [63:0]  nonce_q;
  logic         head_valid, pop;
  item_t        head;
  back_status_t status;

  // Config registers; nonce write also pulses a counter clear into the back end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= '0;
      key_256_q <= 1'b1;
      nonce_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_KEY0:    key_q[0]  <= cfg_wdata_i;
        CFG_KEY1:    key_q[1]  <= cfg_wdata_i;
        CFG_KEY2:    key_q[2]  <= cfg_wdata_i;
        CFG_KEY3:    key_q[3]  <= cfg_wdata_i;
        CFG_KEY_256: key_256_q <= cfg_wdata_i[0];
        CFG_NONCE:   nonce_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg = '{key: key_q, key_256: key_256_q, nonce: nonce_q,
                 nonce_wr: cfg_we_i && (cfg_index_i == CFG_NONCE)};

  // Front: accept and saturate, park items in a two-entry queue.
  chacha_front #(.Limit(Limit)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .message_bytes_i (message_bytes_i),
    .byte_count_i    (byte_count_i),
    .message_end_i   (message_end_i),
    .head_valid_o    (head_valid),
    .head_o          (head),
    .pop_i           (pop)
  );

  // Back: consume keystream, make blocks on demand, drive the output register.
  chacha_back #(.NumRounds(NumRounds)) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .head_valid_i      (head_valid),
    .head_i            (head),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .cipher_bytes_o    (cipher_bytes_o),
    .out_byte_count_o  (out_byte_count_o),
    .out_message_end_o (out_message_end_o),
    .status_o          (status)
  );

`ifndef ASSERT_OFF
  // results never report more bytes than the lane limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_byte_count_o <= 4'(Limit)))
    else $error("output byte count above limit");

  // lanes past the byte count are zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((cipher_bytes_o >> {out_byte_count_o, 3'b000}) == 64'd0))
    else $error("unused output lane not zero");

  // no item is stepped while a block is in the making
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.gen_busy |-> !status.step)
    else $error("item stepped during block generation");
`endif

endmodule
